/* hw/rtl/msp_pkg.sv */
`timescale 1ns / 1ps

package msp_pkg;

    // Default number of motor channels.
    localparam int CHANNELS_DEF = 3;

    // Stream payload widths (whole bytes).
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd6;

    // Serial divider widths: dividend/quotient and divisor.
    localparam int DIV_W  = 26;
    localparam int DIVR_W = 16;

    // Output scaling: dividing by 20 is a multiply by 3277 and a shift by 16,
    // exact for magnitudes up to OUT_SAT, the point beyond any drive limit (20 * 256).
    localparam logic signed [17:0] OUT_RECIP = 18'sd3277;
    localparam int OUT_SHIFT = 16;
    localparam int OUT_SAT   = 5120;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* hw/rtl/msp_div.sv */
`timescale 1ns / 1ps

module msp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  msp_pkg::div_req_t req,
    output msp_pkg::div_rsp_t rsp
);
    import msp_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIVR_W-1:0] dvsr_reg;

    logic [DIVR_W:0]   trial;
    logic              fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIVR_W'(trial - {1'b0, dvsr_reg});
            end
            else
            begin
                rem_reg <= trial[DIVR_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* hw/rtl/motor_speed_pid_top.sv */
// An update runs the sequencer through its states and a 26-step serial division by the
// period; with a zero period the division is skipped. Without an update (period not
// elapsed, or channel out of range) the check goes straight to the output state.
// One item at a time; s_tready returns the cycle after the result is loaded into the
// output register, and that load waits for any output stall.
// Reset: asynchronous active low; config returns to defaults, all channel state to zero.
`timescale 1ns / 1ps

module motor_speed_pid_top #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata fields from bit 0: motor[1:0], now_ms[33:2],
    // target_velocity[49:34], position[81:50], zero fill.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [msp_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata fields from bit 0: drive[8:0], measured_velocity[24:9], zero fill.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [msp_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser fields from bit 0: updated.
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import msp_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_CHECK      = 4'd1;
    localparam logic [3:0] ST_ERR        = 4'd2;
    localparam logic [3:0] ST_SUM        = 4'd3;
    localparam logic [3:0] ST_MULD       = 4'd4;
    localparam logic [3:0] ST_DIVD_START = 4'd5;
    localparam logic [3:0] ST_DIVD_WAIT  = 4'd6;
    localparam logic [3:0] ST_MULP       = 4'd7;
    localparam logic [3:0] ST_ACC1       = 4'd8;
    localparam logic [3:0] ST_MULI       = 4'd9;
    localparam logic [3:0] ST_MULIP      = 4'd10;
    localparam logic [3:0] ST_ACC2       = 4'd11;
    localparam logic [3:0] ST_MULO       = 4'd12;
    localparam logic [3:0] ST_FIN        = 4'd13;
    localparam logic [3:0] ST_OUT        = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic [15:0] period_reg;
    logic [7:0]  kp_reg;
    logic [7:0]  ki_reg;
    logic [7:0]  kd_reg;
    logic [14:0] ilim_reg;
    logic [7:0]  olim_reg;
    logic [7:0]  dband_reg;

    // Per-channel state.
    logic signed [17:0] integral_q   [CHANNELS];
    logic signed [17:0] prev_err_q   [CHANNELS];
    logic        [31:0] last_time_q  [CHANNELS];
    logic signed [8:0]  held_drive_q [CHANNELS];
    logic        [31:0] prev_pos_q   [CHANNELS];
    logic signed [15:0] speed_q      [CHANNELS];

    // Latched input item.
    logic [1:0]         motor_reg;
    logic [31:0]        now_reg;
    logic signed [15:0] target_reg;
    logic [31:0]        pos_reg;

    // Working registers.
    logic signed [15:0] speed_reg;
    logic signed [16:0] err_reg;
    logic signed [17:0] sum_reg;
    logic signed [17:0] de_reg;
    logic signed [44:0] prod_reg;
    logic signed [26:0] dterm_reg;
    logic signed [43:0] acc_reg;
    logic               neg_reg;

    // Result waiting for the output register.
    logic signed [8:0]  res_drive_reg;
    logic signed [15:0] res_vel_reg;
    logic               res_upd_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // Shared divider.
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [IDX_W-1:0]   ci;
    logic               in_range;
    logic               elapsed;
    logic signed [31:0] delta;
    logic signed [15:0] speed_sat;
    logic [16:0]        abs_err;
    logic signed [17:0] base_sum;
    logic signed [17:0] lim_s;
    logic signed [17:0] clamp_sum;
    logic signed [26:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [44:0] mul_p;
    logic [25:0]        prod_mag;
    logic signed [43:0] pd_sum;
    logic [43:0]        acc_mag;
    logic [25:0]        acc_sat;
    logic [8:0]         out_quo;
    logic [8:0]         drv_mag;
    logic signed [9:0]  drv_s;
    logic               out_free;

    assign ci       = IDX_W'(motor_reg);
    assign in_range = (32'(motor_reg) < CHANNELS);
    assign out_free = !m_tvalid_reg || m_tready;

    // Time test and saturated position delta.
    assign elapsed = ((now_reg - last_time_q[ci]) >= {16'd0, period_reg});
    assign delta   = $signed(pos_reg - prev_pos_q[ci]);

    always_comb
    begin
        priority if (delta > 32'sd32767)
        begin
            speed_sat = 16'sh7FFF;
        end
        else if (delta < -32'sd32768)
        begin
            speed_sat = 16'sh8000;
        end
        else
        begin
            speed_sat = delta[15:0];
        end
    end

    // Integral preparation: deadband clear, then symmetric clamp.
    assign abs_err  = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
    assign base_sum = (abs_err < {9'd0, dband_reg}) ? 18'sd0 : integral_q[ci];
    assign lim_s    = $signed({3'b000, ilim_reg});

    always_comb
    begin
        priority if (base_sum > lim_s)
        begin
            clamp_sum = lim_s;
        end
        else if (base_sum < -lim_s)
        begin
            clamp_sum = -lim_s;
        end
        else
        begin
            clamp_sum = base_sum;
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (state_reg)
            ST_MULD:
            begin
                mul_a = {{9{de_reg[17]}}, de_reg};
                mul_b = {10'd0, kd_reg};
            end
            ST_MULP:
            begin
                mul_a = {{10{err_reg[16]}}, err_reg};
                mul_b = {10'd0, kp_reg};
            end
            ST_MULI:
            begin
                mul_a = {{9{sum_reg[17]}}, sum_reg};
                mul_b = {10'd0, ki_reg};
            end
            ST_MULIP:
            begin
                mul_a = prod_reg[26:0];
                mul_b = {2'b00, period_reg};
            end
            ST_MULO:
            begin
                mul_a = {1'b0, acc_sat};
                mul_b = OUT_RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Magnitudes for the divider and the proportional plus derivative sum.
    assign prod_mag = prod_reg[44] ? 26'(-prod_reg) : 26'(prod_reg);
    assign pd_sum   = 44'($signed(prod_reg[26:0])) + 44'(dterm_reg);
    assign acc_mag  = acc_reg[43] ? 44'(-acc_reg) : 44'(acc_reg);
    assign acc_sat  = (acc_mag >= 44'(OUT_SAT)) ? 26'(OUT_SAT) : 26'(acc_mag);

    // Drive magnitude from the scaling product, then clamp and sign.
    assign out_quo = prod_reg[OUT_SHIFT+8:OUT_SHIFT];
    assign drv_mag = (out_quo > {1'b0, olim_reg}) ? {1'b0, olim_reg} : out_quo;
    assign drv_s   = neg_reg ? -$signed({1'b0, drv_mag[8:0]}) : $signed({1'b0, drv_mag[8:0]});

    // Divider requests.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_mag;
        div_req.divisor  = period_reg;
        unique case (state_reg)
            ST_DIVD_START:
            begin
                div_req.start = (period_reg != 16'd0);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    msp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (in_range && elapsed)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_ERR:        state_next = ST_SUM;
            ST_SUM:        state_next = ST_MULD;
            ST_MULD:       state_next = ST_DIVD_START;
            ST_DIVD_START:
            begin
                if (period_reg == 16'd0)
                begin
                    state_next = ST_MULP;
                end
                else
                begin
                    state_next = ST_DIVD_WAIT;
                end
            end
            ST_DIVD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MULP;
                end
            end
            ST_MULP:       state_next = ST_ACC1;
            ST_ACC1:       state_next = ST_MULI;
            ST_MULI:       state_next = ST_MULIP;
            ST_MULIP:      state_next = ST_ACC2;
            ST_ACC2:       state_next = ST_MULO;
            ST_MULO:       state_next = ST_FIN;
            ST_FIN:        state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 16'd10;
            kp_reg     <= 8'd20;
            ki_reg     <= 8'd1;
            kd_reg     <= 8'd10;
            ilim_reg   <= 15'd100;
            olim_reg   <= 8'd255;
            dband_reg  <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD_MS:    period_reg <= cfg_data;
                REG_GAIN_PROP:    kp_reg     <= cfg_data[7:0];
                REG_GAIN_INT:     ki_reg     <= cfg_data[7:0];
                REG_GAIN_DERIV:   kd_reg     <= cfg_data[7:0];
                REG_INT_LIMIT:    ilim_reg   <= cfg_data[14:0];
                REG_OUTPUT_LIMIT: olim_reg   <= cfg_data[7:0];
                REG_DEADBAND:     dband_reg  <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Per-channel state, written when an update finishes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                integral_q[i]   <= '0;
                prev_err_q[i]   <= '0;
                last_time_q[i]  <= '0;
                held_drive_q[i] <= '0;
                prev_pos_q[i]   <= '0;
                speed_q[i]      <= '0;
            end
        end
        else if (state_reg == ST_FIN)
        begin
            integral_q[ci]   <= sum_reg;
            prev_err_q[ci]   <= {err_reg[16], err_reg};
            last_time_q[ci]  <= now_reg;
            held_drive_q[ci] <= drv_s[8:0];
            prev_pos_q[ci]   <= pos_reg;
            speed_q[ci]      <= speed_reg;
        end
    end

    // Input latch and datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                motor_reg  <= s_tdata[1:0];
                now_reg    <= s_tdata[33:2];
                target_reg <= s_tdata[49:34];
                pos_reg    <= s_tdata[81:50];
            end
            ST_CHECK:
            begin
                speed_reg <= speed_sat;
                if (!in_range)
                begin
                    res_drive_reg <= '0;
                    res_vel_reg   <= '0;
                    res_upd_reg   <= 1'b0;
                end
                else
                begin
                    res_drive_reg <= held_drive_q[ci];
                    res_vel_reg   <= speed_q[ci];
                    res_upd_reg   <= 1'b0;
                end
            end
            ST_ERR:
            begin
                err_reg <= {target_reg[15], target_reg} - {speed_reg[15], speed_reg};
            end
            ST_SUM:
            begin
                sum_reg <= clamp_sum + {err_reg[16], err_reg};
                de_reg  <= {err_reg[16], err_reg} - prev_err_q[ci];
            end
            ST_MULD, ST_MULP, ST_MULI, ST_MULIP:
            begin
                prod_reg <= mul_p;
            end
            ST_DIVD_START:
            begin
                neg_reg   <= prod_reg[44];
                dterm_reg <= '0;
            end
            ST_DIVD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dterm_reg <= neg_reg ? -$signed({1'b0, div_rsp.quotient})
                                         : $signed({1'b0, div_rsp.quotient});
                end
            end
            ST_ACC1:
            begin
                acc_reg <= (pd_sum <<< 4) + (pd_sum <<< 2);
            end
            ST_ACC2:
            begin
                acc_reg <= acc_reg + 44'(prod_reg);
            end
            ST_MULO:
            begin
                prod_reg <= mul_p;
                neg_reg  <= acc_reg[43];
            end
            ST_FIN:
            begin
                res_drive_reg <= drv_s[8:0];
                res_vel_reg   <= speed_reg;
                res_upd_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register: loads the finished result when the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_tdata_reg <= {7'd0, res_vel_reg, res_drive_reg};
            m_tuser_reg <= res_upd_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hw/rtl/msp_checker.sv */
`timescale 1ns / 1ps

module msp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [msp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import msp_pkg::*;

    // The block works on one item at a time, so it drops ready after a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready stayed high after an input transaction");

    // A result passes through the check state first; none appears right after an input.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after an input transaction");

    // Drive stays within the symmetric range and the fill bits stay zero.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[8:0] != 9'h100) && (m_tdata[31:25] == 7'd0)))
        else $error("drive out of range or fill bits set");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind motor_speed_pid_top msp_checker u_msp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
